[sv/cfp_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the command frame parser.
package cfp_pkg;

  localparam int MAX_PARAMS = 32;
  localparam int PARAM_AW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int QDEPTH     = 2;   // power of two: the queue pointers wrap freely
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [8:0]  COUNT_CAP   = 9'd300;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [7:0]  HEADER_INIT = 8'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_CRC      = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  cmd_type;
    logic [7:0]  params_len;
    logic [5:0]  param_index;
    logic [7:0]  param_byte;
    logic        param_valid;
    logic [15:0] frame_crc;
    logic        last;
  } out_t;

  // One verdict per frame, front to back
  typedef struct packed {
    status_t     status;
    logic [7:0]  cmd_type;
    logic [7:0]  params_len;
    logic [15:0] frame_crc;
    logic        multi;     // ok with parameters: one result per byte
  } verdict_t;

  typedef struct packed {
    logic                en;
    logic [PARAM_AW-1:0] addr;
    logic [7:0]          data;
  } mem_wr_t;

  typedef struct packed {
    logic param_done;   // last result of a parameter frame taken
  } back_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/cfp_front.sv]
// Front end: takes frame bytes, tracks the CRC and fields, writes parameters, forms verdicts.
module cfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfp_pkg::in_t        in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output cfp_pkg::verdict_t   push_data,
  output cfp_pkg::mem_wr_t    mem_wr,
  input  cfp_pkg::back_stat_t back_stat
);

  logic [7:0]  header_r;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic        busy_r;    // a parameter frame is still being read out of the store
  logic        accept;
  logic [8:0]  pi;
  logic [8:0]  len_ext;
  cfp_pkg::status_t st;

  assign accept   = in_valid && in_ready;
  assign in_ready = push_ready && !busy_r;
  assign len_ext  = {1'b0, len_r};
  assign pi       = count_r - 9'd3;

  always_comb begin
    count_nxt = count_r;
    first_nxt = first_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    mem_wr    = '0;
    mem_wr.addr = pi[cfp_pkg::PARAM_AW-1:0];
    mem_wr.data = in_data.byte_value;
    if (count_r == 9'd0) begin
      first_nxt = in_data.byte_value;
      crc_nxt   = cfp_pkg::crc_byte(crc_r, in_data.byte_value);
    end else if (count_r == 9'd1) begin
      type_nxt = in_data.byte_value;
      crc_nxt  = cfp_pkg::crc_byte(crc_r, in_data.byte_value);
    end else if (count_r == 9'd2) begin
      len_nxt = in_data.byte_value;
      crc_nxt = cfp_pkg::crc_byte(crc_r, in_data.byte_value);
    end else if (count_r < len_ext + 9'd3) begin
      mem_wr.en = accept && (pi < 9'(cfp_pkg::MAX_PARAMS));
      crc_nxt   = cfp_pkg::crc_byte(crc_r, in_data.byte_value);
    end else if (count_r == len_ext + 9'd3) begin
      rcrc_nxt = {in_data.byte_value, 8'h00};
    end else if (count_r == len_ext + 9'd4) begin
      rcrc_nxt = {rcrc_r[15:8], in_data.byte_value};
    end
    if (count_r < cfp_pkg::COUNT_CAP) begin
      count_nxt = count_r + 9'd1;
    end

    if (count_nxt < 9'd4) begin
      st = cfp_pkg::ST_SHORT;
    end else if (first_nxt != header_r) begin
      st = cfp_pkg::ST_BAD_HDR;
    end else if (count_nxt < {1'b0, len_nxt} + 9'd5) begin
      st = cfp_pkg::ST_SHORT;
    end else if (crc_nxt != rcrc_nxt) begin
      st = cfp_pkg::ST_CRC;
    end else if (len_nxt > 8'(cfp_pkg::MAX_PARAMS)) begin
      st = cfp_pkg::ST_OVERFLOW;
    end else begin
      st = cfp_pkg::ST_OK;
    end

    push_valid           = accept && in_data.frame_end;
    push_data.status     = st;
    push_data.cmd_type   = type_nxt;
    push_data.params_len = len_nxt;
    push_data.frame_crc  = rcrc_nxt;
    push_data.multi      = (st == cfp_pkg::ST_OK) && (len_nxt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= cfp_pkg::HEADER_INIT;
      count_r  <= '0;
      first_r  <= '0;
      type_r   <= '0;
      len_r    <= '0;
      crc_r    <= cfp_pkg::CRC_INIT;
      rcrc_r   <= '0;
      busy_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        header_r <= cfg_data;
      end
      if (accept) begin
        if (in_data.frame_end) begin
          count_r <= '0;
          first_r <= '0;
          type_r  <= '0;
          len_r   <= '0;
          crc_r   <= cfp_pkg::CRC_INIT;
          rcrc_r  <= '0;
        end else begin
          count_r <= count_nxt;
          first_r <= first_nxt;
          type_r  <= type_nxt;
          len_r   <= len_nxt;
          crc_r   <= crc_nxt;
          rcrc_r  <= rcrc_nxt;
        end
      end
      if (push_valid && push_data.multi) begin
        busy_r <= 1'b1;
      end else if (back_stat.param_done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

[sv/cfp_queue.sv]
// Short verdict queue between the front end and the result sequencer.
module cfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  cfp_pkg::verdict_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cfp_pkg::verdict_t pop_data
);

  cfp_pkg::verdict_t     entry_r [cfp_pkg::QDEPTH];
  logic [cfp_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [cfp_pkg::QAW:0]   count_r;
  logic                    do_push, do_pop;

  assign push_ready = count_r != cfp_pkg::QAW'(0) + (cfp_pkg::QAW+1)'(cfp_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[sv/cfp_back.sv]
// Result sequencer: holds the parameter store and emits one result per verdict or parameter.
module cfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cfp_pkg::mem_wr_t    mem_wr,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  cfp_pkg::verdict_t   pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cfp_pkg::out_t       out_data,
  output cfp_pkg::back_stat_t back_stat
);

  logic [7:0] store_r [cfp_pkg::MAX_PARAMS];
  logic [7:0] rd_data_r;

  cfp_pkg::back_state_t state_r, state_nxt;
  cfp_pkg::verdict_t    vd_r, vd_nxt;
  logic [5:0]           idx_r, idx_nxt;
  logic                 is_last;
  logic                 taken;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store_r[mem_wr.addr] <= mem_wr.data;
    end
    rd_data_r <= store_r[idx_r[cfp_pkg::PARAM_AW-1:0]];
  end

  assign is_last = !vd_r.multi || ({2'b00, idx_r} + 8'd1 == vd_r.params_len);
  assign taken   = (state_r == cfp_pkg::BK_SEND) && out_ready;

  always_comb begin
    state_nxt = state_r;
    vd_nxt    = vd_r;
    idx_nxt   = idx_r;
    pop_ready = 1'b0;
    back_stat.param_done = taken && is_last && vd_r.multi;
    case (state_r)
      cfp_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          vd_nxt    = pop_data;
          idx_nxt   = '0;
          state_nxt = pop_data.multi ? cfp_pkg::BK_READ : cfp_pkg::BK_SEND;
        end
      end
      cfp_pkg::BK_READ: begin
        state_nxt = cfp_pkg::BK_SEND;
      end
      cfp_pkg::BK_SEND: begin
        if (out_ready) begin
          if (is_last) begin
            state_nxt = cfp_pkg::BK_IDLE;
          end else begin
            idx_nxt   = idx_r + 6'd1;
            state_nxt = cfp_pkg::BK_READ;
          end
        end
      end
      default: begin
        state_nxt = cfp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfp_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    vd_r  <= vd_nxt;
    idx_r <= idx_nxt;
  end

  always_comb begin
    out_valid            = state_r == cfp_pkg::BK_SEND;
    out_data.status      = vd_r.status;
    out_data.cmd_type    = vd_r.cmd_type;
    out_data.params_len  = vd_r.params_len;
    out_data.param_index = vd_r.multi ? idx_r : 6'd0;
    out_data.param_byte  = vd_r.multi ? rd_data_r : 8'd0;
    out_data.param_valid = vd_r.multi;
    out_data.frame_crc   = vd_r.frame_crc;
    out_data.last        = is_last;
  end

endmodule

[sv/command_frame_parser_crc16_top.sv]
// Top level of the framed command parser with CRC-16/CCITT-FALSE check.
//
//   channel  | ports                         | carries
//   ---------+-------------------------------+-----------------------------------
//   input    | in_valid / in_ready / in_data | one received byte, end-of-buffer flag
//   result   | out_valid/out_ready/out_data  | verdict or one parameter byte
//   config   | cfg_we / cfg_data             | expected header byte (reset 1)
//
// Bytes are taken one per cycle while in_ready is high; the CRC is updated a byte at a
// time in the front end. A frame end pushes one verdict into a two-entry queue, which the
// sequencer pops while idle. An error or empty frame then offers its single result; a
// parameter frame offers one result per parameter, each after a store read (read, then
// send). After each verdict the sequencer returns to idle to pop the next. The input is
// held off while the queue is full and while a parameter request is being read out of
// the store.
// Synchronous active-low reset; the parameter store is not cleared.
module command_frame_parser_crc16_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cfp_pkg::out_t out_data
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  cfp_pkg::verdict_t   push_data, pop_data;
  cfp_pkg::mem_wr_t    mem_wr;
  cfp_pkg::back_stat_t back_stat;

  // Front end: byte parsing, CRC, header check
  cfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .mem_wr     (mem_wr),
    .back_stat  (back_stat)
  );

  // Verdict queue decoupling the two halves
  cfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Result sequencer with the parameter store
  cfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_wr    (mem_wr),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .back_stat (back_stat)
  );

endmodule

[tb/sv/frame_parser_checker.sv]
// Checker for the command frame parser: predicts results from accepted bytes and compares them.
module frame_parser_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic  [7:0]   cfg_data,
  input  logic          in_valid,
  input  logic          in_ready,
  input  cfp_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  cfp_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);

  logic [7:0]    hdr_cfg;
  logic [8:0]    nbytes;
  logic [7:0]    first_b;
  logic [7:0]    cmd_r;
  logic [7:0]    len_r;
  logic [15:0]   crc_run;
  logic [15:0]   crc_rx;
  logic [7:0]    pstore [cfp_pkg::MAX_PARAMS];
  cfp_pkg::out_t expected_q [$];
  int            fails = 0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ cfp_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic clear_frame();
    nbytes  = '0;
    first_b = '0;
    cmd_r   = '0;
    len_r   = '0;
    crc_run = cfp_pkg::CRC_INIT;
    crc_rx  = '0;
  endtask

  // One accepted request: update the frame state, queue results on a frame end
  task automatic absorb_byte(input logic [7:0] b, input logic fend);
    int               pos;
    cfp_pkg::status_t st;
    cfp_pkg::out_t    r;
    pos = nbytes;
    if (pos == 0) begin
      first_b = b;
      crc_run = crc16_byte(crc_run, b);
    end else if (pos == 1) begin
      cmd_r   = b;
      crc_run = crc16_byte(crc_run, b);
    end else if (pos == 2) begin
      len_r   = b;
      crc_run = crc16_byte(crc_run, b);
    end else if (pos < 3 + int'(len_r)) begin
      if (pos - 3 < cfp_pkg::MAX_PARAMS) pstore[pos-3] = b;
      crc_run = crc16_byte(crc_run, b);
    end else if (pos == 3 + int'(len_r)) begin
      crc_rx = {b, 8'h00};
    end else if (pos == 4 + int'(len_r)) begin
      crc_rx[7:0] = b;
    end
    if (nbytes < cfp_pkg::COUNT_CAP) nbytes = nbytes + 9'd1;
    if (!fend) return;

    if (nbytes < 9'd4) st = cfp_pkg::ST_SHORT;
    else if (first_b != hdr_cfg) st = cfp_pkg::ST_BAD_HDR;
    else if (int'(nbytes) < 5 + int'(len_r)) st = cfp_pkg::ST_SHORT;
    else if (crc_run != crc_rx) st = cfp_pkg::ST_CRC;
    else if (int'(len_r) > cfp_pkg::MAX_PARAMS) st = cfp_pkg::ST_OVERFLOW;
    else st = cfp_pkg::ST_OK;

    r = '0;
    r.cmd_type   = cmd_r;
    r.params_len = len_r;
    r.frame_crc  = crc_rx;
    if (st != cfp_pkg::ST_OK || len_r == 8'd0) begin
      r.status = st;
      r.last   = 1'b1;
      expected_q.push_back(r);
    end else begin
      for (int i = 0; i < int'(len_r); i++) begin
        r.status      = cfp_pkg::ST_OK;
        r.param_index = 6'(i);
        r.param_byte  = pstore[i];
        r.param_valid = 1'b1;
        r.last        = (i + 1 == int'(len_r));
        expected_q.push_back(r);
      end
    end
    clear_frame();
  endtask

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cfp_pkg::out_t want;
    if (!rst_n) begin
      hdr_cfg = cfp_pkg::HEADER_INIT;
      clear_frame();
      expected_q.delete();
    end else begin
      if (cfg_we) hdr_cfg = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d type 0x%0h idx %0d",
                 out_data.status, out_data.cmd_type, out_data.param_index);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("status",      16'(want.status),      16'(out_data.status));
          check_field("cmd_type",    16'(want.cmd_type),    16'(out_data.cmd_type));
          check_field("params_len",  16'(want.params_len),  16'(out_data.params_len));
          check_field("param_index", 16'(want.param_index), 16'(out_data.param_index));
          check_field("param_byte",  16'(want.param_byte),  16'(out_data.param_byte));
          check_field("param_valid", 16'(want.param_valid), 16'(out_data.param_valid));
          check_field("frame_crc",   want.frame_crc,        out_data.frame_crc);
          check_field("last",        16'(want.last),        16'(out_data.last));
        end
      end
      if (in_valid && in_ready) absorb_byte(in_data.byte_value, in_data.frame_end);
    end
    fail_count <= fails;
    pending    <= expected_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top for the command frame parser: stimulus, receiver stalls and verdict.
module testbench;

  localparam int BYTES_PER_PHASE = 110;  // with the directed frames, roughly 500 requests
  localparam int HOLD_CYCLES     = 300;  // long receiver hold-off, enough to back the block up
  localparam int STALL_LIMIT     = 4000; // cycles with no request or result moving
  localparam int SETTLE_CYCLES   = 8;    // frame bytes with no verdict may still be in flight
  localparam int DRAIN_CYCLES    = 20;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic cfg_we   = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  cfp_pkg::in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cfp_pkg::out_t out_data;

  int fail_count;
  int pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int bytes_sent = 0;

  logic [7:0] hdr_now = cfp_pkg::HEADER_INIT;  // header value the block currently expects
  logic [7:0] frame_q [$];                     // bytes of the frame being built

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  command_frame_parser_crc16_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  frame_parser_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver. A toggle of hold_req starts a long hold-off, counted here; otherwise
  // ready drops at random with the current idle percentage.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // CRC-16/CCITT-FALSE, one bit at a time, for building frames
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ cfp_pkg::CRC_POLY;
    end
    return c;
  endfunction

  // Offer one request, idling first at random; returns at the edge it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.byte_value   <= b;
    in_data.frame_end    <= fend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Whole frame with random parameters; a bad CRC gets one bit flipped
  task automatic make_frame(input logic [7:0] hdr, input logic [7:0] ctype,
                            input logic [7:0] plen, input bit crc_ok);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_q.delete();
    crc = cfp_pkg::CRC_INIT;
    frame_q.push_back(hdr);
    frame_q.push_back(ctype);
    frame_q.push_back(plen);
    crc = crc_feed(crc_feed(crc_feed(crc, hdr), ctype), plen);
    for (int i = 0; i < int'(plen); i++) begin
      b = 8'($urandom_range(255));
      frame_q.push_back(b);
      crc = crc_feed(crc, b);
    end
    if (!crc_ok) crc = crc ^ (16'd1 << $urandom_range(15));
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
  endtask

  task automatic add_trailing(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic cut_tail(input int n);
    repeat (n) void'(frame_q.pop_back());
  endtask

  // The last byte of the buffer carries the frame end flag
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    hdr_now  = v;
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise
  task automatic random_frame();
    int pick;
    int plen;
    pick = $urandom_range(99);
    plen = ($urandom_range(4) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
    if (pick < 60) begin
      make_frame(hdr_now, 8'($urandom_range(255)), 8'(plen), 1'b1);
      if ($urandom_range(4) == 0) add_trailing($urandom_range(1, 3));
      send_frame();
    end else if (pick < 64) begin
      // parameter count beyond the store
      make_frame(hdr_now, 8'($urandom_range(255)), 8'($urandom_range(33, 40)), 1'b1);
      send_frame();
    end else if (pick < 65) begin
      // long frame; with enough trailing bytes the byte count saturates
      make_frame(hdr_now, 8'($urandom_range(255)), 8'($urandom_range(200, 255)), 1'b1);
      add_trailing($urandom_range(0, 60));
      send_frame();
    end else if (pick < 73) begin
      make_frame(hdr_now, 8'($urandom_range(255)), 8'(plen), 1'b0);
      send_frame();
    end else if (pick < 80) begin
      make_frame(hdr_now ^ 8'($urandom_range(1, 255)), 8'($urandom_range(255)), 8'(plen), 1'b1);
      if ($urandom_range(1) == 0) cut_tail($urandom_range(0, frame_q.size() - 1));
      send_frame();
    end else if (pick < 89) begin
      // frame end arrives early
      make_frame(hdr_now, 8'($urandom_range(255)), 8'(plen), 1'b1);
      cut_tail($urandom_range(1, frame_q.size() - 1));
      send_frame();
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  task automatic run_phase(input int target);
    int stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the header left at its reset value
    make_frame(hdr_now, 8'h00, 8'd0, 1'b1);    send_frame();  // empty parameter list
    make_frame(hdr_now, 8'hFF, 8'd1, 1'b1);    send_frame();
    make_frame(hdr_now, 8'h5A, 8'd32, 1'b1);   send_frame();  // store exactly full
    make_frame(hdr_now, 8'hA5, 8'd33, 1'b1);   send_frame();  // one past the store
    frame_q.delete(); frame_q.push_back(hdr_now); send_frame();  // single byte: too short
    make_frame(hdr_now, 8'h11, 8'd0, 1'b1); cut_tail(2); send_frame();  // three bytes
    make_frame(hdr_now, 8'h22, 8'd0, 1'b1); cut_tail(1); send_frame();  // CRC half there
    make_frame(8'hFE, 8'h33, 8'd2, 1'b1);      send_frame();  // wrong header
    make_frame(8'hFE, 8'h34, 8'd9, 1'b1); cut_tail(9); send_frame();  // wrong header, short
    make_frame(hdr_now, 8'h44, 8'd2, 1'b0);    send_frame();  // CRC mismatch
    make_frame(hdr_now, 8'h55, 8'd3, 1'b1); add_trailing(4); send_frame();  // bytes after CRC
    make_frame(hdr_now, 8'h77, 8'd6, 1'b1); cut_tail(4); send_frame();  // ends in parameters

    // Header register extremes
    write_header(8'h00);
    make_frame(8'h00, 8'h80, 8'd4, 1'b1);      send_frame();
    make_frame(8'h01, 8'h81, 8'd4, 1'b1);      send_frame();
    write_header(8'hFF);
    make_frame(8'hFF, 8'h7F, 8'd5, 1'b1);      send_frame();
    make_frame(8'h7F, 8'h7E, 8'd0, 1'b1);      send_frame();

    // Random phase: sender idles a little, receiver a lot
    write_header(8'($urandom_range(255)));
    send_idle_pct = 29;
    recv_idle_pct = 76;
    run_phase(BYTES_PER_PHASE);

    // The other way round, with a pause until every request has been answered
    write_header(8'($urandom_range(255)));
    send_idle_pct = 76;
    recv_idle_pct = 29;
    run_phase(BYTES_PER_PHASE / 2);
    drain();
    run_phase(BYTES_PER_PHASE / 2);

    // Full rate; the receiver holds off for a long stretch while requests keep coming
    write_header(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = ~hold_req;
    run_phase(BYTES_PER_PHASE);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cfp_pkg.sv
sv/cfp_front.sv
sv/cfp_queue.sv
sv/cfp_back.sv
sv/command_frame_parser_crc16_top.sv
tb/sv/frame_parser_checker.sv
tb/sv/testbench.sv
